@@ hdl/priority_aware_flow_sampler_macros.svh @@
// ----------------------------------------------------------------------------
// Flow sampler assertion macros
// Shared property forms for the sampler's port checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_AWARE_FLOW_SAMPLER_MACROS_SVH
`define PRIORITY_AWARE_FLOW_SAMPLER_MACROS_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define PAFS_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define PAFS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hdl/pafs_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow sampler package
// Types, hash constants and helper functions shared by the sampler modules.
// ----------------------------------------------------------------------------
package pafs_pkg;

	localparam logic [31:0] ALL_ONES    = 32'hffffffff;
	localparam logic [31:0] PRE_SEED    = 32'd77123;
	localparam logic [31:0] TALLY_SEED  = 32'd91234;
	localparam logic [31:0] MIX_C1      = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2      = 32'h1b873593;
	localparam logic [31:0] MIX_ADD     = 32'he6546b64;
	localparam logic [31:0] FIN_C1      = 32'h85ebca6b;
	localparam logic [31:0] FIN_C2      = 32'hc2b2ae35;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_PRIO    = 4;

	// Configuration register indexes.
	localparam logic [2:0] REG_PRESAMPLE = 3'd0;
	localparam logic [2:0] REG_WEIGHT_1  = 3'd1;
	localparam logic [2:0] REG_WEIGHT_4  = 3'd4;

	typedef logic [31:0] word_t;

	// One classified packet handed from the front to the back.
	typedef struct packed {
		logic [31:0] src;
		logic [2:0]  prio;
		logic        passed;
		logic [31:0] h_pre;
		logic [31:0] h_sample;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  sampled_prio;
		logic [31:0] sampled_src;
		logic        sampled;
		logic        slot_raised;
		logic        passed_presample;
	} result_t;

	// Configuration write as seen by the back part.
	typedef struct packed {
		logic        we;
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_FOLD,
		ST_READ,
		ST_UPDATE,
		ST_SUM,
		ST_MUL,
		ST_NUM,
		ST_CMP,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} back_state_t;

	function automatic word_t rotl13(input word_t x);
		return {x[18:0], x[31:19]};
	endfunction

	function automatic word_t rotl15(input word_t x);
		return {x[16:0], x[31:17]};
	endfunction

	// Hash value reduced modulo all ones.
	function automatic word_t mod_ones(input word_t h);
		return (h == ALL_ONES) ? 32'd0 : h;
	endfunction

	// Block and tail rounds plus the length fold, given the mixed key word.
	function automatic word_t hash_body(input word_t seed, input word_t k,
			input logic [3:0] len);
		word_t h;
		h = seed;
		if (len >= 4'd4) begin
			h = h ^ k;
			h = rotl13(h);
			h = (h << 2) + h + MIX_ADD;
			if (len == 4'd8) begin
				h = rotl13(h);
				h = (h << 2) + h + MIX_ADD;
			end
		end else if (len != 4'd0) begin
			h = h ^ k;
		end
		h = h ^ {28'd0, len};
		h = h ^ (h >> 16);
		return h;
	endfunction

endpackage

@@ hdl/priority_aware_flow_sampler.sv @@
// ----------------------------------------------------------------------------
// Priority aware flow sampler
// Per-packet pre-sampling, per-slot priority tracking and sample decision.
// ----------------------------------------------------------------------------
// Usage: packets enter on the s_ channel (source key, destination key and
// priority), one result per packet leaves on the m_ channel in arrival order.
// Registers are to be written by the user on the cfg_ channel only while no
// packet is in flight; the block does not enforce it. cfg_ready is always high.
// A packet passes the hashing pipeline and a four entry queue before the slot
// sequencer takes it. The sequencer sends a packet that fails pre-sampling or
// has an ignored priority straight to the output; one that does not raise its
// slot also reads and updates its slot; one that raises it goes on through the
// sum, multiply, numerator and compare states and the threshold division,
// which retires one quotient bit per cycle (the division is skipped when the
// quotient saturates). When REG_COUNT is not a power of two, the slot index
// first takes a reciprocal multiply and fold. The sequencer takes a new packet
// only once the last result is in the output register, so it sets the rate.
// After reset the slot priority memory is cleared entry by entry;
// s_tready stays low during that sweep. When the receiver stalls, the result
// holds in the output register and the queue fills; s_tready falls once every
// queue place is claimed.
// ----------------------------------------------------------------------------
module priority_aware_flow_sampler
	import pafs_pkg::*;
#(
	parameter int REG_COUNT  = 4096,
	parameter int KEY_BYTES  = 4,
	parameter int PRIORITIES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // src_key[31:0], dst_key[63:32], prio[66:64], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // passed_presample[0], slot_raised[1], sampled[2],
	                               // sampled_src[34:3], sampled_prio[37:35], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic    [31:0] presample_q;
	word_t          weight_q [MAX_PRIO];
	cfg_wr_t        cfg_wr;
	logic           clear_done;
	logic           push, q_valid, q_pop;
	item_t          push_item, q_item;
	result_t        result;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.we    = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presample_q <= ALL_ONES;
			for (int i = 0; i < MAX_PRIO; i++)
				weight_q[i] <= ALL_ONES;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PRESAMPLE)
				presample_q <= cfg_data;
			else if (cfg_index >= REG_WEIGHT_1 && cfg_index <= REG_WEIGHT_4)
				weight_q[2'(cfg_index - 3'd1)] <= cfg_data;
		end
	end

	pafs_front #(
		.KEY_BYTES(KEY_BYTES)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.enable             (clear_done),
		.s_valid            (s_tvalid),
		.s_ready            (s_tready),
		.src_key            (s_tdata[31:0]),
		.dst_key            (s_tdata[63:32]),
		.prio               (s_tdata[66:64]),
		.presample_threshold(presample_q),
		.slot_freed         (q_pop),
		.push               (push),
		.push_item          (push_item)
	);

	pafs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_item (q_item)
	);

	pafs_back #(
		.REG_COUNT (REG_COUNT),
		.PRIORITIES(PRIORITIES)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr             (cfg_wr),
		.presample_threshold(presample_q),
		.weight             (weight_q),
		.q_valid            (q_valid),
		.q_item             (q_item),
		.q_pop              (q_pop),
		.clear_done         (clear_done),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.out_result         (result)
	);

	assign m_tdata = {2'b00, result};

endmodule

@@ hdl/pafs_queue.sv @@
// ----------------------------------------------------------------------------
// Flow sampler item queue
// Short FIFO that decouples the hashing front from the slot update back.
// ----------------------------------------------------------------------------
module pafs_queue
	import pafs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  pop_valid,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pointer and fill count; the front never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

endmodule

@@ hdl/pafs_front.sv @@
// ----------------------------------------------------------------------------
// Flow sampler front
// Accepts packets, hashes the folded key with both seeds in a six stage
// pipeline and classifies the pre-sampling test.
// ----------------------------------------------------------------------------
module pafs_front
	import pafs_pkg::*;
#(
	parameter int KEY_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        enable,
	input  logic        s_valid,
	output logic        s_ready,
	input  logic [31:0] src_key,
	input  logic [31:0] dst_key,
	input  logic [2:0]  prio,
	input  logic [31:0] presample_threshold,
	input  logic        slot_freed,
	output logic        push,
	output item_t       push_item
);

	localparam int LEN       = (KEY_BYTES > 8) ? 8 : KEY_BYTES;
	localparam int MSG_BYTES = (LEN < 4) ? LEN : 4;
	localparam logic [31:0] KEY_MASK = 32'hffffffff >> (32 - 8 * MSG_BYTES);
	localparam logic [3:0]  LEN_C    = 4'(LEN);
	localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

	logic [CRED_W-1:0] credits_q;
	logic              accept;
	logic [6:1]        vld_q;
	logic [31:0] src_s1, src_s2, src_s3, src_s4, src_s5, src_s6;
	logic [2:0]  prio_s1, prio_s2, prio_s3, prio_s4, prio_s5, prio_s6;
	logic [31:0] k_s1, k_s2, k_s3;
	logic [31:0] hp_s4, hp_s5, hp_s6;
	logic [31:0] hs_s4, hs_s5, hs_s6;
	logic [31:0] hp_fin, hs_fin;

	assign s_ready = enable && (credits_q != '0);
	assign accept  = s_valid && s_ready;

	// Credits count queue places not yet claimed by items in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= CRED_W'(QUEUE_DEPTH);
		end else if (accept && !slot_freed) begin
			credits_q <= credits_q - 1'b1;
		end else if (slot_freed && !accept) begin
			credits_q <= credits_q + 1'b1;
		end
	end

	// Valid bits of the hash pipeline, which never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[5:1], accept};
	end

	// Hash pipeline: key fold, block mix, rounds, two finalizer multiplies.
	always_ff @(posedge clk) begin
		src_s1  <= src_key;
		prio_s1 <= prio;
		k_s1    <= (src_key ^ dst_key) & KEY_MASK;

		src_s2  <= src_s1;
		prio_s2 <= prio_s1;
		k_s2    <= k_s1 * MIX_C1;

		src_s3  <= src_s2;
		prio_s3 <= prio_s2;
		k_s3    <= rotl15(k_s2) * MIX_C2;

		src_s4  <= src_s3;
		prio_s4 <= prio_s3;
		hp_s4   <= hash_body(PRE_SEED, k_s3, LEN_C);
		hs_s4   <= hash_body(TALLY_SEED, k_s3, LEN_C);

		src_s5  <= src_s4;
		prio_s5 <= prio_s4;
		hp_s5   <= hp_s4 * FIN_C1;
		hs_s5   <= hs_s4 * FIN_C1;

		src_s6  <= src_s5;
		prio_s6 <= prio_s5;
		hp_s6   <= (hp_s5 ^ (hp_s5 >> 13)) * FIN_C2;
		hs_s6   <= (hs_s5 ^ (hs_s5 >> 13)) * FIN_C2;
	end

	assign hp_fin = hp_s6 ^ (hp_s6 >> 16);
	assign hs_fin = hs_s6 ^ (hs_s6 >> 16);

	// Classified item into the queue.
	assign push               = vld_q[6];
	assign push_item.src      = src_s6;
	assign push_item.prio     = prio_s6;
	assign push_item.passed   = (mod_ones(hp_fin) <= presample_threshold);
	assign push_item.h_pre    = hp_fin;
	assign push_item.h_sample = hs_fin;

endmodule

@@ hdl/pafs_back.sv @@
// ----------------------------------------------------------------------------
// Flow sampler back
// Sequencer that picks the slot, raises its priority, moves the slot counts,
// makes the sample decision and recomputes the threshold with a serial divider.
// ----------------------------------------------------------------------------
module pafs_back
	import pafs_pkg::*;
#(
	parameter int REG_COUNT  = 4096,
	parameter int PRIORITIES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg_wr,
	input  logic [31:0] presample_threshold,
	input  word_t       weight [MAX_PRIO],
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        clear_done,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_result
);

	localparam int SLOT_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int CNT_W   = $clog2(REG_COUNT + 1);
	localparam int D_W     = 32 + CNT_W;
	localparam int NUM_W   = 64 + CNT_W;
	localparam bit IS_POW2 = ((1 << SLOT_W) == REG_COUNT);
	localparam logic [31:0]      REG_COUNT_W = 32'(REG_COUNT);
	localparam logic [CNT_W-1:0] REG_COUNT_C = CNT_W'(REG_COUNT);
	localparam logic [2:0]       PRIO_TOP    = 3'(PRIORITIES);
	// Rounded-up reciprocal of the slot count; exact quotient for any 32-bit hash.
	localparam int          FOLD_SH    = 32 + SLOT_W;
	localparam logic [63:0] RECIP_WIDE =
			((64'd1 << FOLD_SH) + 64'(REG_COUNT) - 64'd1) / 64'(REG_COUNT);
	localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];

	back_state_t       state_q, state_d;
	item_t             item_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] clr_addr_q;
	logic [4:0]        bit_q;
	logic [2:0]        mem_q [REG_COUNT];
	logic [2:0]        rd_data_q;
	logic              rd_en;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_addr;
	logic [2:0]        mem_wdata;
	logic [CNT_W-1:0]  cnt_q [MAX_PRIO];
	word_t             thr_q [MAX_PRIO];
	logic              raised_q, sampled_q;
	logic [CNT_W-1:0]  rest_q;
	logic [D_W-1:0]    a_q, d_q, rem_q;
	logic [NUM_W-1:0]  num_q;
	word_t             quot_q;
	logic [31:0]       fold_q;
	logic [64:0]       recip_prod;
	logic [1:0]        pidx;
	logic [1:0]        oidx;
	logic              prio_ok;
	logic [D_W:0]      div_shift;
	logic [CNT_W-1:0]  sum;

	assign pidx    = 2'(item_q.prio - 3'd1);
	assign oidx    = 2'(rd_data_q - 3'd1);
	assign prio_ok = (item_q.prio >= 3'd1) && (item_q.prio <= PRIO_TOP);

	// Slot quotient by reciprocal multiply, and the threshold division step.
	assign recip_prod = {33'd0, item_q.h_pre} * {32'd0, RECIP};
	assign div_shift  = {rem_q, num_q[bit_q]};

	// Slot counts from this priority up.
	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_PRIO; i++) begin
			if (i < PRIORITIES && 2'(i) >= pidx)
				sum = sum + cnt_q[i];
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == SLOT_W'(REG_COUNT - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (!q_item.passed || !(q_item.prio >= 3'd1 && q_item.prio <= PRIO_TOP))
						state_d = ST_OUT;
					else if (IS_POW2)
						state_d = ST_READ;
					else
						state_d = ST_MOD;
				end
			end
			ST_MOD:  state_d = ST_FOLD;
			ST_FOLD: state_d = ST_READ;
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = (rd_data_q < item_q.prio) ? ST_SUM : ST_OUT;
			end
			ST_SUM:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_NUM;
			ST_NUM:  state_d = ST_CMP;
			ST_CMP: begin
				if (d_q == '0 || num_q[NUM_W-1:32] >= d_q)
					state_d = ST_WRITE;
				else
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (bit_q == 5'd0)
					state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	assign clear_done = (state_q != ST_CLEAR);

	// Slot priority memory: clearing sweep, or raise of the current slot.
	assign mem_we    = (state_q == ST_CLEAR) ||
			(state_q == ST_UPDATE && rd_data_q < item_q.prio);
	assign mem_addr  = (state_q == ST_CLEAR) ? clr_addr_q : slot_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? 3'd0 : item_q.prio;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_addr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= mem_q[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (state_q == ST_CLEAR)
			clr_addr_q <= clr_addr_q + 1'b1;
	end

	// Slot counts and sample thresholds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PRIO; i++) begin
				cnt_q[i] <= '0;
				thr_q[i] <= ALL_ONES;
			end
		end else begin
			if (cfg_wr.we && cfg_wr.index >= REG_WEIGHT_1 && cfg_wr.index <= REG_WEIGHT_4)
				thr_q[2'(cfg_wr.index - 3'd1)] <= cfg_wr.data;
			if (state_q == ST_WRITE)
				thr_q[pidx] <= quot_q;
			if (state_q == ST_UPDATE && rd_data_q < item_q.prio) begin
				for (int i = 0; i < MAX_PRIO; i++) begin
					if (2'(i) == pidx)
						cnt_q[i] <= cnt_q[i] + 1'b1;
					else if (rd_data_q != 3'd0 && 2'(i) == oidx)
						cnt_q[i] <= cnt_q[i] - 1'b1;
				end
			end
		end
	end

	// Item datapath: slot remainder, decision, threshold division.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q    <= q_item;
				raised_q  <= 1'b0;
				sampled_q <= 1'b0;
				bit_q     <= 5'd31;
				slot_q    <= IS_POW2 ? q_item.h_pre[SLOT_W-1:0] : '0;
			end
			ST_MOD:  fold_q <= 32'(recip_prod >> FOLD_SH);
			ST_FOLD: slot_q <= SLOT_W'(item_q.h_pre - fold_q * REG_COUNT_W);
			ST_UPDATE: begin
				if (rd_data_q < item_q.prio) begin
					raised_q  <= 1'b1;
					sampled_q <= (mod_ones(item_q.h_sample) <= thr_q[pidx]);
				end
			end
			ST_SUM: rest_q <= REG_COUNT_C - sum;
			ST_MUL: begin
				a_q <= D_W'(weight[pidx]) * D_W'(REG_COUNT_C);
				d_q <= D_W'(presample_threshold) * D_W'(rest_q);
			end
			ST_NUM: num_q <= {a_q, 32'd0} - NUM_W'(a_q);
			ST_CMP: begin
				rem_q  <= num_q[NUM_W-1:32];
				quot_q <= ALL_ONES;
				bit_q  <= 5'd31;
			end
			ST_DIV: begin
				if (div_shift >= {1'b0, d_q}) begin
					rem_q  <= D_W'(div_shift - {1'b0, d_q});
					quot_q <= {quot_q[30:0], 1'b1};
				end else begin
					rem_q  <= D_W'(div_shift);
					quot_q <= {quot_q[30:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register; holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_result.passed_presample <= item_q.passed;
			out_result.slot_raised      <= raised_q && prio_ok;
			out_result.sampled          <= sampled_q && prio_ok;
			out_result.sampled_src      <= (sampled_q && prio_ok) ? item_q.src : 32'd0;
			out_result.sampled_prio     <= (sampled_q && prio_ok) ? item_q.prio : 3'd0;
		end
	end

endmodule

@@ hdl/pafs_checker.sv @@
// ----------------------------------------------------------------------------
// Flow sampler port checker
// Watches the sampler's ports for result consistency and output stability.
// ----------------------------------------------------------------------------
`include "priority_aware_flow_sampler_macros.svh"

module pafs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data
);

	// A stalled result keeps its value.
	`PAFS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// A slot is raised only by a packet that passed pre-sampling.
	`PAFS_ASSERT_NOW(a_raise_passed, m_tvalid && m_tdata[1], m_tdata[0], "raise without pre-sampling pass")

	// A sampled packet always raised its slot.
	`PAFS_ASSERT_NOW(a_sample_raised, m_tvalid && m_tdata[2], m_tdata[1], "sample without slot raise")

	// Echo fields stay zero unless the packet is sampled.
	`PAFS_ASSERT_NOW(a_echo_zero, m_tvalid && !m_tdata[2], m_tdata[39:3] == 37'd0, "echo set while not sampled")

endmodule

bind priority_aware_flow_sampler pafs_checker u_pafs_checker (.*);
